// ----- hdl/sem_pkg.sv -----
// shared constants and types for the sobel edge magnitude block
`default_nettype none
package sem_pkg;

  // frame geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAG_LIMIT  = 255;

  // field and counter widths
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = FH_W;
  localparam int CNT_W      = 23;
  localparam int PIX_W      = 24;
  localparam int GRAD_W     = 11;
  localparam int SUM_W      = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // register reset values
  localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(768);

  // largest sum whose rounded root does not exceed the limit
  localparam logic [15:0] ROOT_MAX = 16'(MAG_LIMIT * MAG_LIMIT + MAG_LIMIT);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // one masked 3x3 neighborhood waiting for the magnitude unit
  typedef struct packed {
    pix_t [8:0] box;
    logic       last;
  } job_t;

  // push request and queue full flag from the front part
  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage
`default_nettype wire

// ----- hdl/sem_ifs.sv -----
// channel interfaces: pixel input, result output, register writes
`default_nettype none
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;
  modport source (output valid, command, in_blue, in_green, in_red, input ready);
  modport sink (input valid, command, in_blue, in_green, in_red, output ready);
endinterface

interface sem_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic       last_of_frame;
  modport source (output valid, out_blue, out_green, out_red, last_of_frame, input ready);
  modport sink (input valid, out_blue, out_green, out_red, last_of_frame, output ready);
endinterface

interface sem_cfg_if;
  import sem_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/sobel_edge_magnitude_rgb_core.sv -----
// top level: sobel edge magnitude on rgb raster streams
// the front takes a transaction only while idle (line store read, then update, which waits while the queue is full);
// the shared root unit finishes one result before it pops the next (gradient, square, 8 root digits, output)
// reset clears counters, window, handshakes and sets width 1024, height 768;
// line stores are not cleared and take no clearing pass
`default_nettype none
module sobel_edge_magnitude_rgb_core (
  input  wire logic clk,
  input  wire logic rst,
  sem_pix_if.sink   pix,
  sem_res_if.source res,
  sem_cfg_if.sink   cfg
);
  import sem_pkg::*;

  job_t  push_job;
  job_t  head;
  qctl_t qctl_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  // window and raster control
  sem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .cfg       (cfg),
    .job       (push_job),
    .qctl_push (qctl_push),
    .q_full    (q_full)
  );

  // decoupling queue
  sem_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_job  (push_job),
    .qctl_push (qctl_push),
    .full      (q_full),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop)
  );

  // magnitude unit
  sem_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (q_empty),
    .pop   (q_pop),
    .res   (res)
  );

endmodule
`default_nettype wire

// ----- hdl/sem_ram.sv -----
// generic single write port, single registered read port ram
`default_nettype none
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sem_front.sv -----
// front part: registers, raster counters, line stores, window, neighborhood masking
`default_nettype none
module sem_front (
  input  wire logic   clk,
  input  wire logic   rst,
  sem_pix_if.sink     pix,
  sem_cfg_if.sink     cfg,
  output sem_pkg::job_t  job,
  output sem_pkg::qctl_t qctl_push,
  input  wire logic   q_full
);
  import sem_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_PROC = 2'b10
  } fstate_t;

  fstate_t state, state_next;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [FW_W-1:0]  used_w;
  logic [FH_W-1:0]  used_h;
  logic [FW_W+FH_W-1:0] prod;
  logic [CNT_W-1:0] total;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CNT_W-1:0] out_cnt;
  pix_t             px;
  pix_t             win [9];
  pix_t             win_next [9];
  pix_t             prev_q;
  pix_t             prev2_q;
  logic             cfg_wr;
  logic             cfg_known;
  logic             accept;
  logic             flush;
  logic             draining;
  logic             take;
  logic             have_a;
  logic             have_b;
  logic             have;
  logic             go;
  logic             last;
  logic             col_end;
  logic [ROW_W-1:0] orow;
  logic [FW_W-1:0]  ocol;
  logic             m_top;
  logic             m_bot;
  logic             m_left;
  logic             m_right;

  // register port never stalls
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign cfg_known = (cfg.idx == CFG_FRAME_WIDTH) || (cfg.idx == CFG_FRAME_HEIGHT);

  // saturate the geometry registers
  always_comb begin
    if (frame_width == '0) begin
      used_w = FW_W'(1);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      used_w = FW_W'(MAX_WIDTH);
    end else begin
      used_w = frame_width;
    end
    if (frame_height == '0) begin
      used_h = FH_W'(1);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      used_h = FH_W'(MAX_HEIGHT);
    end else begin
      used_h = frame_height;
    end
  end

  // pixels per frame, registered after the multiply
  assign prod = (FW_W+FH_W)'(used_w) * (FW_W+FH_W)'(used_h);
  always_ff @(posedge clk) begin
    total <= prod[CNT_W-1:0];
  end

  // classify the incoming transaction
  assign pix.ready = (state == F_IDLE);
  assign accept    = pix.valid && pix.ready;
  assign flush     = (pix.command == CMD_FLUSH);
  assign draining  = (row >= ROW_W'(used_h));
  assign take      = accept && (flush == draining);

  // hold the pixel until the line stores answer
  always_ff @(posedge clk) begin
    if (take) begin
      px <= flush ? '0 : {pix.in_red, pix.in_green, pix.in_blue};
    end
  end

  // line stores: read when a transaction is taken, rotate on completion
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk     (clk),
    .wr_en   (go),
    .wr_addr (col),
    .wr_data (px),
    .rd_en   (take),
    .rd_addr (col),
    .rd_data (prev_q)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev2 (
    .clk     (clk),
    .wr_en   (go),
    .wr_addr (col),
    .wr_data (prev_q),
    .rd_en   (take),
    .rd_addr (col),
    .rd_data (prev2_q)
  );

  // window shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i*3]     = win[i*3+1];
      win_next[i*3+1]   = win[i*3+2];
    end
    win_next[2] = prev2_q;
    win_next[5] = prev_q;
    win_next[8] = px;
  end

  // which output position this transaction finishes
  assign have_a  = (col == '0) && (row >= ROW_W'(2));
  assign have_b  = (col != '0) && (row != '0);
  assign have    = have_a || have_b;
  assign orow    = have_a ? row - ROW_W'(2) : row - ROW_W'(1);
  assign ocol    = have_a ? used_w - FW_W'(1) : FW_W'(col) - FW_W'(1);
  assign m_top   = (orow == '0);
  assign m_bot   = ({1'b0, orow} + (ROW_W+1)'(1)) >= {1'b0, used_h};
  assign m_left  = (ocol == '0);
  assign m_right = ({1'b0, ocol} + (FW_W+1)'(1)) >= {1'b0, used_w};
  assign col_end = ({1'b0, col} + (COL_W+1)'(1)) >= (COL_W+1)'(used_w);
  assign last    = (out_cnt + CNT_W'(1)) >= total;
  assign go      = (state == F_PROC) && (!have || !q_full);

  // black out neighbors outside the frame
  always_comb begin
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        if ((rr == 0 && m_top) || (rr == 2 && m_bot) ||
            (cc == 0 && m_left) || (cc == 2 && m_right)) begin
          job.box[rr*3+cc] = '0;
        end else begin
          job.box[rr*3+cc] = win_next[rr*3+cc];
        end
      end
    end
    job.last = last;
  end

  assign qctl_push.push = go && have;
  assign qctl_push.full = q_full;

  // next state
  always_comb begin
    case (state)
      F_IDLE:  state_next = take ? F_PROC : F_IDLE;
      F_PROC:  state_next = go ? F_IDLE : F_PROC;
      default: state_next = F_IDLE;
    endcase
  end

  // control state, counters, registers, window
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      col          <= '0;
      row          <= '0;
      out_cnt      <= '0;
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr && cfg_known) begin
        if (cfg.idx == CFG_FRAME_WIDTH) begin
          frame_width <= cfg.data[FW_W-1:0];
        end else begin
          frame_height <= cfg.data[FH_W-1:0];
        end
        col     <= '0;
        row     <= '0;
        out_cnt <= '0;
      end
      if (go) begin
        win <= win_next;
        if (col_end) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
        if (have) begin
          out_cnt <= out_cnt + CNT_W'(1);
          if (last) begin
            col     <= '0;
            row     <= '0;
            out_cnt <= '0;
          end
        end
      end
    end
  end

  // a result is never pushed into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    qctl_push.push |-> !q_full)
    else $error("push into full queue");

  // a taken transaction always goes to the line store stage
  a_take_proc: assert property (@(posedge clk) disable iff (rst)
    take |=> state == F_PROC)
    else $error("taken transaction not processed");

  // a stalled transaction leaves the raster position alone
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == F_PROC) && !go |=> $stable(col) && $stable(row) && $stable(out_cnt))
    else $error("counters moved while stalled");

endmodule
`default_nettype wire

// ----- hdl/sem_queue.sv -----
// two-entry queue between the front and the magnitude unit
`default_nettype none
module sem_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sem_pkg::job_t  push_job,
  input  wire sem_pkg::qctl_t qctl_push,
  output logic                full,
  output sem_pkg::job_t       head,
  output logic                empty,
  input  wire logic           pop
);
  import sem_pkg::*;

  job_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rp];

  // storage
  always_ff @(posedge clk) begin
    if (qctl_push.push) begin
      slot[wp] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (qctl_push.push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({qctl_push.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sem_back.sv -----
// back part: sobel gradients, squared sum and rounded root per channel
`default_nettype none
module sem_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sem_pkg::job_t head,
  input  wire logic          empty,
  output logic               pop,
  sem_res_if.source          res
);
  import sem_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SQ   = 4'b0010,
    B_ROOT = 4'b0100,
    B_DONE = 4'b1000
  } bstate_t;

  bstate_t state, state_next;

  logic signed [GRAD_W-1:0]   ga_c [3];
  logic signed [GRAD_W-1:0]   gb_c [3];
  logic signed [GRAD_W-1:0]   ga [3];
  logic signed [GRAD_W-1:0]   gb [3];
  logic signed [2*GRAD_W-1:0] pa [3];
  logic signed [2*GRAD_W-1:0] pb [3];
  logic [SUM_W-1:0]           ssum [3];
  logic [15:0]                sval [3];
  logic                       clamp [3];
  logic [11:0]                rem [3];
  logic [7:0]                 root [3];
  logic [11:0]                rem_sh [3];
  logic [11:0]                trial [3];
  logic [7:0]                 mag [3];
  logic [2:0]                 step;
  logic                       last;
  logic                       out_load;

  // weighted sum of three taps, weights one, two, one
  function automatic logic signed [GRAD_W-1:0] tap3(input logic [7:0] a,
                                                   input logic [7:0] m,
                                                   input logic [7:0] z);
    tap3 = $signed({3'b000, a}) + $signed({2'b00, m, 1'b0}) + $signed({3'b000, z});
  endfunction

  // gradients straight off the queue head, lane 0 blue, 1 green, 2 red
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      ga_c[ch] = tap3(head.box[6][ch*8 +: 8], head.box[7][ch*8 +: 8], head.box[8][ch*8 +: 8])
               - tap3(head.box[0][ch*8 +: 8], head.box[1][ch*8 +: 8], head.box[2][ch*8 +: 8]);
      gb_c[ch] = tap3(head.box[2][ch*8 +: 8], head.box[5][ch*8 +: 8], head.box[8][ch*8 +: 8])
               - tap3(head.box[0][ch*8 +: 8], head.box[3][ch*8 +: 8], head.box[6][ch*8 +: 8]);
    end
  end

  // squares and their sum
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      pa[ch]   = ga[ch] * ga[ch];
      pb[ch]   = gb[ch] * gb[ch];
      ssum[ch] = pa[ch][SUM_W-1:0] + pb[ch][SUM_W-1:0];
    end
  end

  // one root digit per cycle, remainder kept for rounding
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rem_sh[ch] = {rem[ch][9:0], sval[ch][15:14]};
      trial[ch]  = {2'b00, root[ch], 2'b01};
      if (clamp[ch]) begin
        mag[ch] = 8'(MAG_LIMIT);
      end else if (rem[ch] <= {4'd0, root[ch]}) begin
        mag[ch] = root[ch];
      end else begin
        mag[ch] = root[ch] + 8'd1;
      end
    end
  end

  assign pop      = (state == B_IDLE) && !empty;
  assign out_load = (state == B_DONE) && (!res.valid || res.ready);

  // next state
  always_comb begin
    case (state)
      B_IDLE:  state_next = pop ? B_SQ : B_IDLE;
      B_SQ:    state_next = B_ROOT;
      B_ROOT:  state_next = (step == 3'd7) ? B_DONE : B_ROOT;
      B_DONE:  state_next = out_load ? B_IDLE : B_DONE;
      default: state_next = B_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (pop) begin
        ga[ch] <= ga_c[ch];
        gb[ch] <= gb_c[ch];
      end
      if (state == B_SQ) begin
        clamp[ch] <= ssum[ch] > {5'd0, ROOT_MAX};
        sval[ch]  <= ssum[ch][15:0];
        rem[ch]   <= '0;
        root[ch]  <= '0;
      end else if (state == B_ROOT) begin
        sval[ch] <= {sval[ch][13:0], 2'b00};
        if (rem_sh[ch] >= trial[ch]) begin
          rem[ch]  <= rem_sh[ch] - trial[ch];
          root[ch] <= {root[ch][6:0], 1'b1};
        end else begin
          rem[ch]  <= rem_sh[ch];
          root[ch] <= {root[ch][6:0], 1'b0};
        end
      end
    end
    if (pop) begin
      last <= head.last;
    end
    if (out_load) begin
      res.out_blue      <= mag[0];
      res.out_green     <= mag[1];
      res.out_red       <= mag[2];
      res.last_of_frame <= last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_ROOT) begin
        step <= step + 3'd1;
      end else begin
        step <= '0;
      end
      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // a popped job always goes on to the square stage
  a_pop_sq: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == B_SQ)
    else $error("popped job lost");

  // the root takes exactly eight digit steps
  a_root_len: assert property (@(posedge clk) disable iff (rst)
    (state == B_ROOT) && (step == 3'd7) |=> state == B_DONE)
    else $error("root iteration count wrong");

  // the output register is loaded only with a finished result
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == B_DONE))
    else $error("result shown before it was done");

endmodule
`default_nettype wire
